### rtl/sac_pkg.sv
// ----------------------------------------------------------------------------
// sac_pkg
// Shared widths, register indexes, defaults and control types for the
// set-associative cache tag controller.
// ----------------------------------------------------------------------------
package sac_pkg;

    // parameter defaults
    localparam int SETS_DEF      = 64;
    localparam int WAYS_DEF      = 4;
    localparam int ADDR_BITS_DEF = 32;

    // fixed field widths
    localparam int ADDR_FIELD_W = 32;
    localparam int OFFSET_W     = 4;
    localparam int INDEX_W      = 3;
    localparam int WAY_OUT_W    = 2;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_WRITE_BACK   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACE_FIFO = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INDEX_BITS   = 2'd3;

    // register reset values
    localparam logic                WRITE_BACK_RST   = 1'b1;
    localparam logic                REPLACE_FIFO_RST = 1'b0;
    localparam logic [OFFSET_W-1:0] OFFSET_BITS_RST  = 4'd4;
    localparam logic [INDEX_W-1:0]  INDEX_BITS_RST   = 3'd6;

    // largest k with 2^k <= n, capped at 12
    function automatic int floor_log2(input int n);
        int k;
        k = 0;
        for (int i = 1; i <= 12; i++)
        begin
            if ((1 << i) <= n)
            begin
                k = i;
            end
        end
        return k;
    endfunction

    // controller to datapath commands
    typedef struct packed {
        logic capture;  // take the request beat, read the set row
        logic commit;   // resolve the lookup, update the set, load result
    } sac_cmd_t;

endpackage

### rtl/sac_ctrl.sv
// ----------------------------------------------------------------------------
// sac_ctrl
// Sequencer: accepts a request, runs the lookup cycle, owns the result
// valid flag.
// ----------------------------------------------------------------------------
module sac_ctrl
    import sac_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    output sac_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_LOOKUP = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    assign slot_free   = !out_valid_reg || m_tready;
    assign s_tready    = (state_reg == ST_IDLE);
    assign cmd.capture = s_tvalid && (state_reg == ST_IDLE);
    assign cmd.commit  = (state_reg == ST_LOOKUP) && slot_free;
    assign m_tvalid    = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.capture)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // a captured request always gets its lookup cycle next
    a_capture_to_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> state_reg == ST_LOOKUP)
        else $error("capture not followed by lookup");

    // a committed lookup always presents a result
    a_commit_to_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("commit without result");

    // a blocked lookup holds until the result slot frees
    a_lookup_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOOKUP) && !slot_free |=> state_reg == ST_LOOKUP)
        else $error("lookup left while result slot busy");

endmodule

### rtl/sac_datapath.sv
// ----------------------------------------------------------------------------
// sac_datapath
// Address split, set row memory (tags, ranks, dirty), valid flops, way
// compare, victim choice, rank/dirty update and the result register.
// ----------------------------------------------------------------------------
module sac_datapath
    import sac_pkg::*;
#(
    parameter int SETS      = SETS_DEF,
    parameter int WAYS      = WAYS_DEF,
    parameter int ADDR_BITS = ADDR_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  sac_cmd_t                cmd,
    input  logic                    is_store,
    input  logic [ADDR_FIELD_W-1:0] address,
    output logic                    hit,
    output logic                    fill_read,
    output logic                    mem_write,
    output logic [WAY_OUT_W-1:0]    way_used
);

    localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int TAG_W  = (ADDR_BITS < ADDR_FIELD_W) ? ADDR_BITS : ADDR_FIELD_W;
    localparam int MAX_IB = floor_log2(SETS);
    localparam logic [63:0] ADDR_MASK_W = (64'd1 << TAG_W) - 64'd1;

    // configuration
    logic                write_back_reg;
    logic                replace_fifo_reg;
    logic [OFFSET_W-1:0] offset_bits_reg;
    logic [INDEX_W-1:0]  index_bits_reg;

    // request
    logic             req_store_reg;
    logic [TAG_W-1:0] req_tag_reg;
    logic [SET_W-1:0] req_set_reg;

    // set row memory and its read register
    logic [WAYS-1:0][TAG_W-1:0] tag_mem   [SETS];
    logic [WAYS-1:0][WAY_W-1:0] rank_mem  [SETS];
    logic [WAYS-1:0]            dirty_mem [SETS];
    logic [WAYS-1:0][TAG_W-1:0] tag_rd_reg;
    logic [WAYS-1:0][WAY_W-1:0] rank_rd_reg;
    logic [WAYS-1:0]            dirty_rd_reg;

    logic [SETS-1:0][WAYS-1:0] valid_reg;

    // result register
    logic                 hit_reg;
    logic                 fill_reg;
    logic                 wr_reg;
    logic [WAY_W-1:0]     way_reg;

    // address split
    logic [ADDR_FIELD_W-1:0] addr_m;
    logic [ADDR_FIELD_W-1:0] shifted;
    logic [ADDR_FIELD_W-1:0] tag_full;
    logic [INDEX_W-1:0]      ib_eff;
    logic [SET_W-1:0]        set_mask;
    logic [SET_W-1:0]        set_next;
    logic [TAG_W-1:0]        tag_next;

    always_comb
    begin
        addr_m   = address & ADDR_MASK_W[ADDR_FIELD_W-1:0];
        ib_eff   = (int'(index_bits_reg) > MAX_IB) ? INDEX_W'(MAX_IB) : index_bits_reg;
        shifted  = addr_m >> offset_bits_reg;
        set_mask = ~({SET_W{1'b1}} << ib_eff);
        set_next = shifted[SET_W-1:0] & set_mask;
        tag_full = shifted >> ib_eff;
        tag_next = tag_full[TAG_W-1:0];
    end

    // lookup
    logic [WAYS-1:0]            valid_row;
    logic [WAYS-1:0]            hit_vec;
    logic [WAYS-1:0]            dirty_g;
    logic [WAYS-1:0][WAY_W-1:0] rank_g;
    logic [WAYS-1:0][WAY_W-1:0] rank_new;
    logic [WAYS-1:0][TAG_W-1:0] tag_new;
    logic [WAYS-1:0]            dirty_new;
    logic                       any_hit;
    logic                       any_inv;
    logic [WAY_W-1:0]           hit_way;
    logic [WAY_W-1:0]           inv_way;
    logic [WAY_W-1:0]           lru_way;
    logic [WAY_W-1:0]           sel_way;
    logic [WAY_W-1:0]           sel_rank;
    logic                       promote_en;
    logic                       wr_next;

    always_comb
    begin
        valid_row = valid_reg[req_set_reg];
        hit_way   = '0;
        inv_way   = '0;
        lru_way   = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            hit_vec[w] = valid_row[w] && (tag_rd_reg[w] == req_tag_reg);
            dirty_g[w] = valid_row[w] && dirty_rd_reg[w];
            rank_g[w]  = valid_row[w] ? rank_rd_reg[w] : '0;
            if (hit_vec[w])
            begin
                hit_way = WAY_W'(w);
            end
            if (!valid_row[w])
            begin
                inv_way = WAY_W'(w);
            end
            // valid ranks form a permutation: the bottom rank is the victim
            if (rank_g[w] == '0)
            begin
                lru_way = WAY_W'(w);
            end
        end
        any_hit    = |hit_vec;
        any_inv    = !(&valid_row);
        sel_way    = any_hit ? hit_way : (any_inv ? inv_way : lru_way);
        sel_rank   = rank_g[sel_way];
        promote_en = !any_hit || !replace_fifo_reg;

        for (int w = 0; w < WAYS; w++)
        begin
            if (!promote_en)
            begin
                rank_new[w] = rank_g[w];
            end
            else if (WAY_W'(w) == sel_way)
            begin
                rank_new[w] = WAY_W'(WAYS - 1);
            end
            else if (rank_g[w] > sel_rank)
            begin
                rank_new[w] = rank_g[w] - WAY_W'(1);
            end
            else
            begin
                rank_new[w] = rank_g[w];
            end
        end

        tag_new   = tag_rd_reg;
        dirty_new = dirty_g;
        if (any_hit)
        begin
            if (req_store_reg && write_back_reg)
            begin
                dirty_new[sel_way] = 1'b1;
            end
            wr_next = req_store_reg && !write_back_reg;
        end
        else
        begin
            tag_new[sel_way]   = req_tag_reg;
            dirty_new[sel_way] = req_store_reg && write_back_reg;
            // dirty_g is already gated by valid: only a real eviction counts
            wr_next = dirty_g[sel_way] || (req_store_reg && !write_back_reg);
        end
    end

    // configuration and valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_back_reg   <= WRITE_BACK_RST;
            replace_fifo_reg <= REPLACE_FIFO_RST;
            offset_bits_reg  <= OFFSET_BITS_RST;
            index_bits_reg   <= INDEX_BITS_RST;
            valid_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_WRITE_BACK:   write_back_reg   <= cfg_data[0];
                    REG_REPLACE_FIFO: replace_fifo_reg <= cfg_data[0];
                    REG_OFFSET_BITS:  offset_bits_reg  <= cfg_data[OFFSET_W-1:0];
                    REG_INDEX_BITS:   index_bits_reg   <= cfg_data[INDEX_W-1:0];
                    default:          ;
                endcase
            end
            if (cmd.commit)
            begin
                valid_reg[req_set_reg][sel_way] <= 1'b1;
            end
        end
    end

    // request capture and set row memory
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_store_reg <= is_store;
            req_tag_reg   <= tag_next;
            req_set_reg   <= set_next;
            tag_rd_reg    <= tag_mem[set_next];
            rank_rd_reg   <= rank_mem[set_next];
            dirty_rd_reg  <= dirty_mem[set_next];
        end
        if (cmd.commit)
        begin
            tag_mem[req_set_reg]   <= tag_new;
            rank_mem[req_set_reg]  <= rank_new;
            dirty_mem[req_set_reg] <= dirty_new;
            hit_reg                <= any_hit;
            fill_reg               <= !any_hit;
            wr_reg                 <= wr_next;
            way_reg                <= sel_way;
        end
    end

    logic [WAY_W+WAY_OUT_W-1:0] way_ext;

    assign way_ext   = {{WAY_OUT_W{1'b0}}, way_reg};
    assign way_used  = way_ext[WAY_OUT_W-1:0];
    assign hit       = hit_reg;
    assign fill_read = fill_reg;
    assign mem_write = wr_reg;

endmodule

### rtl/set_assoc_cache_tag_controller.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_controller
// Tag and replacement-policy controller of a set-associative cache (no data
// array): lookup, victim choice (LRU or FIFO), write-back or write-through.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Beat contents
//  --------+-----------+------------------------------------------------------
//  s_*     | in        | tdata[31:0] address; tuser[0] is_store
//  m_*     | out       | tdata[0] hit, [1] fill_read, [2] mem_write,
//          |           | [4:3] way_used, [7:5] zero
//  cfg_*   | in        | write-only: 0 write_back, 1 replace_fifo,
//          |           | 2 offset_bits, 3 index_bits
//
//  A request first has its address split and its set row read from memory,
//  then is compared, picks the victim and writes the row back (single
//  read/write port of the set memory). No new request is taken while a
//  lookup is in progress. The next request is accepted while a result still
//  waits on m_*; a stalled result holds the lookup cycle of the following request.
//  Reset clears the valid bits and restores the register defaults
//  (write-back, LRU, 16-byte lines, 64 sets); no clearing pass is needed.
//
module set_assoc_cache_tag_controller
    import sac_pkg::*;
#(
    parameter int SETS      = SETS_DEF,
    parameter int WAYS      = WAYS_DEF,
    parameter int ADDR_BITS = ADDR_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,

    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [ADDR_FIELD_W-1:0] s_tdata,    // [31:0] address
    input  logic                    s_tuser,    // [0] is_store

    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [7:0]              m_tdata     // hit, fill_read, mem_write,
                                                // way_used[1:0], pad
);

    sac_cmd_t             cmd;
    logic                 hit;
    logic                 fill_read;
    logic                 mem_write;
    logic [WAY_OUT_W-1:0] way_used;

    // sequencer: request accept, lookup slot, result valid
    sac_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // address split, set memory, compare and policy update
    sac_datapath #(
        .SETS      (SETS),
        .WAYS      (WAYS),
        .ADDR_BITS (ADDR_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .is_store  (s_tuser),
        .address   (s_tdata),
        .hit       (hit),
        .fill_read (fill_read),
        .mem_write (mem_write),
        .way_used  (way_used)
    );

    // pack result beat, lowest field first, zero pad to a byte
    assign m_tdata = {3'b000, way_used, mem_write, fill_read, hit};

endmodule
